### design/assert_macros.svh
// assert_macros.svh: concurrent assertion macros used by the allocator top level.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
// Implication after a fixed number of cycles.
`define ASSERT_LATER(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("assertion failed: delayed implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_LATER(label, clk, rst, ante, n, cons)
`endif
`endif

### design/frfa_pkg.sv
// frfa_pkg.sv: shared codes, constants and controller/datapath struct types
// for the frame fenced ring allocator. Depends on nothing.
package frfa_pkg;

   localparam int unsigned FIELD_WIDTH = 32;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE   = 2'd1;
   localparam logic [1:0] STATUS_QUEUE_FULL = 2'd2;

   // Ring size after reset, before truncation to the configured size width.
   localparam logic [63:0] RING_SIZE_RESET = 64'd65536;

   typedef struct packed {
      logic capture;
      logic eval;
      logic update;
      logic pop;
      logic finish;
      logic mod_step;
   } cmd_type;

   typedef struct packed {
      logic pop_ok;
      logic need_mod;
      logic mod_last;
   } sts_type;

endpackage

### design/frfa_ctrl.sv
// frfa_ctrl.sv: sequencing state machine of the frame fenced ring allocator.
// Depends on frfa_pkg for the command and status struct types.
module frfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_operation,
   output logic              busy,
   output frfa_pkg::cmd_type cmd,
   input  frfa_pkg::sts_type sts
);
   import frfa_pkg::*;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_ALLOC_EVAL = 3'd1;
   localparam logic [2:0] ST_ALLOC_UPD  = 3'd2;
   localparam logic [2:0] ST_FREE_POP   = 3'd3;
   localparam logic [2:0] ST_FREE_FIN   = 3'd4;
   localparam logic [2:0] ST_FREE_MOD   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_operation == OP_FREE) ? ST_FREE_POP : ST_ALLOC_EVAL;
            end
         end
         ST_ALLOC_EVAL: begin
            state_in = ST_ALLOC_UPD;
         end
         ST_ALLOC_UPD: begin
            state_in = ST_IDLE;
         end
         ST_FREE_POP: begin
            if (!sts.pop_ok) begin
               state_in = ST_FREE_FIN;
            end
         end
         ST_FREE_FIN: begin
            state_in = sts.need_mod ? ST_FREE_MOD : ST_IDLE;
         end
         ST_FREE_MOD: begin
            if (sts.mod_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy         = (state_ff != ST_IDLE);
      cmd.capture  = (state_ff == ST_IDLE) && start;
      cmd.eval     = (state_ff == ST_ALLOC_EVAL);
      cmd.update   = (state_ff == ST_ALLOC_UPD);
      cmd.pop      = (state_ff == ST_FREE_POP) && sts.pop_ok;
      cmd.finish   = (state_ff == ST_FREE_FIN);
      cmd.mod_step = (state_ff == ST_FREE_MOD);
   end

endmodule

### design/frfa_dpath.sv
// frfa_dpath.sv: ring pointers, record memory, remainder unit and result registers.
// Depends on frfa_pkg; driven by commands from frfa_ctrl.
module frfa_dpath #(
   parameter int RECORD_DEPTH = 16,
   parameter int SIZE_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  frfa_pkg::cmd_type                   cmd,
   output frfa_pkg::sts_type                   sts,
   input  logic                                req_operation,
   input  logic [frfa_pkg::FIELD_WIDTH-1:0]    req_request_size,
   input  logic [frfa_pkg::FIELD_WIDTH-1:0]    req_frame,
   input  logic                                csr_we,
   input  logic [frfa_pkg::FIELD_WIDTH-1:0]    csr_wdata,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [frfa_pkg::FIELD_WIDTH-1:0]    rsp_offset,
   output logic [frfa_pkg::FIELD_WIDTH-1:0]    rsp_freed_bytes,
   output logic [frfa_pkg::FIELD_WIDTH-1:0]    rsp_free_space
);
   import frfa_pkg::*;

   localparam int SW   = SIZE_WIDTH;
   localparam int FW   = FIELD_WIDTH;
   localparam int DW   = (SW > FW) ? SW : FW;
   localparam int EW   = DW + 2;
   localparam int PW   = $clog2(RECORD_DEPTH);
   localparam int CNTW = $clog2(RECORD_DEPTH + 1);
   localparam int MCW  = $clog2(SW);

   // Ring state.
   logic [SW-1:0]   ring_ff, ring_in;
   logic [SW-1:0]   head_ff, head_in;
   logic [SW-1:0]   tail_ff, tail_in;
   logic [SW-1:0]   unused_ff, unused_in;
   logic [PW-1:0]   rp_ff, rp_in;
   logic [PW-1:0]   wp_ff, wp_in;
   logic [CNTW-1:0] count_ff, count_in;

   // Transaction working registers.
   logic [FW-1:0]   req_size_ff, req_size_in;
   logic [FW-1:0]   frame_ff, frame_in;
   logic [EW-1:0]   charge_ff, charge_in;
   logic [SW-1:0]   offset_ff, offset_in;
   logic            wrap_ff, wrap_in;
   logic            need_new_ff, need_new_in;
   logic [1:0]      status_ff, status_in;
   logic [SW-1:0]   rest_ff, rest_in;
   logic [SW-1:0]   used_ff, used_in;
   logic [SW-1:0]   sum_ff, sum_in;
   logic [SW-1:0]   mod_rem_ff, mod_rem_in;
   logic [SW-1:0]   mod_num_ff, mod_num_in;
   logic [MCW-1:0]  mod_cnt_ff, mod_cnt_in;

   // Result registers.
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [FW-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [FW-1:0]   rsp_freed_ff, rsp_freed_in;
   logic [FW-1:0]   rsp_space_ff, rsp_space_in;

   // Record memory; an entry can be read before it is written, and such reads are not used.
   logic [SW-1:0]   rec_bytes_mem [RECORD_DEPTH];
   logic [FW-1:0]   rec_frame_mem [RECORD_DEPTH];
   logic [SW-1:0]   rd_bytes_ff;
   logic [FW-1:0]   rd_frame_ff;
   logic            mem_re;
   logic [PW-1:0]   mem_raddr;
   logic            mem_we;
   logic            mem_wframe;
   logic [PW-1:0]   mem_waddr;
   logic [SW-1:0]   mem_wbytes;

   logic [PW-1:0]   wp_prev;
   logic [PW-1:0]   wp_next;
   logic [PW-1:0]   rp_next;

   always_comb begin
      wp_prev = (wp_ff == '0) ? PW'(RECORD_DEPTH - 1) : wp_ff - 1'b1;
      wp_next = (wp_ff == PW'(RECORD_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      rp_next = (rp_ff == PW'(RECORD_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   end

   always_comb begin
      logic [EW-1:0] req_e;
      logic [EW-1:0] unused_e;
      logic [EW-1:0] ring_e;
      logic [EW-1:0] head_e;
      logic [EW-1:0] tail_e;
      logic [EW-1:0] next_tail_e;
      logic          fits;
      logic          wrap;
      logic          need_new;
      logic [SW-1:0] alloc_unused;
      logic [SW-1:0] free_unused;
      logic [SW-1:0] excess;
      logic [SW:0]   rem_shift;

      req_e       = EW'(req_size_ff);
      unused_e    = EW'(unused_ff);
      ring_e      = EW'(ring_ff);
      head_e      = EW'(head_ff);
      tail_e      = EW'(tail_ff);
      next_tail_e = tail_e + req_e;

      // Contiguity check against the current head and tail.
      fits = 1'b1;
      wrap = 1'b0;
      if (req_e > unused_e) begin
         fits = 1'b0;
      end else if (tail_e >= head_e) begin
         if (req_e > ring_e - tail_e) begin
            if (head_e < req_e) begin
               fits = 1'b0;
            end else begin
               wrap = 1'b1;
            end
         end
      end else if (head_e - tail_e < req_e) begin
         fits = 1'b0;
      end
      need_new = (count_ff == '0) || (rd_frame_ff != frame_ff);

      alloc_unused = (charge_ff > unused_e) ? '0 : SW'(unused_e - charge_ff);
      free_unused  = (sum_ff > used_ff) ? ring_ff : unused_ff + sum_ff;
      excess       = sum_ff - rest_ff;

      // One restoring remainder step.
      rem_shift = {mod_rem_ff, mod_num_ff[SW-1]};
      if (rem_shift >= {1'b0, ring_ff}) begin
         rem_shift = rem_shift - {1'b0, ring_ff};
      end

      sts.pop_ok   = (count_ff != '0) && (rd_frame_ff <= frame_ff);
      sts.need_mod = (sum_ff > rest_ff) && (ring_ff != '0) && (excess >= ring_ff);
      sts.mod_last = (mod_cnt_ff == MCW'(SW - 1));

      ring_in       = ring_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      unused_in     = unused_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      req_size_in   = req_size_ff;
      frame_in      = frame_ff;
      charge_in     = charge_ff;
      offset_in     = offset_ff;
      wrap_in       = wrap_ff;
      need_new_in   = need_new_ff;
      status_in     = status_ff;
      rest_in       = rest_ff;
      used_in       = used_ff;
      sum_in        = sum_ff;
      mod_rem_in    = mod_rem_ff;
      mod_num_in    = mod_num_ff;
      mod_cnt_in    = mod_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_space_in  = rsp_space_ff;
      mem_re        = 1'b0;
      mem_raddr     = rp_ff;
      mem_we        = 1'b0;
      mem_wframe    = 1'b0;
      mem_waddr     = wp_ff;
      mem_wbytes    = charge_ff[SW-1:0];

      if (cmd.capture) begin
         req_size_in = req_request_size;
         frame_in    = req_frame;
         sum_in      = '0;
         rest_in     = (ring_ff >= head_ff) ? ring_ff - head_ff : '0;
         used_in     = ring_ff - unused_ff;
         mem_re      = 1'b1;
         mem_raddr   = (req_operation == OP_FREE) ? rp_ff : wp_prev;
      end

      if (cmd.eval) begin
         wrap_in     = wrap;
         need_new_in = need_new;
         charge_in   = wrap ? req_e + (ring_e - tail_e) : req_e;
         offset_in   = wrap ? '0 : tail_ff;
         if (!fits) begin
            status_in = STATUS_NO_SPACE;
         end else if (need_new && (count_ff >= CNTW'(RECORD_DEPTH))) begin
            status_in = STATUS_QUEUE_FULL;
         end else begin
            status_in = STATUS_OK;
         end
      end

      if (cmd.update) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_freed_in  = '0;
         rsp_offset_in = '0;
         rsp_space_in  = FW'(unused_ff);
         if (status_ff == STATUS_OK) begin
            if (wrap_ff) begin
               tail_in = SW'(req_size_ff);
            end else begin
               tail_in = (next_tail_e >= ring_e) ? '0 : next_tail_e[SW-1:0];
            end
            unused_in     = alloc_unused;
            rsp_offset_in = FW'(offset_ff);
            rsp_space_in  = FW'(alloc_unused);
            mem_we        = 1'b1;
            if (need_new_ff) begin
               mem_wframe = 1'b1;
               mem_waddr  = wp_ff;
               mem_wbytes = charge_ff[SW-1:0];
               wp_in      = wp_next;
               count_in   = count_ff + 1'b1;
            end else begin
               mem_waddr  = wp_prev;
               mem_wbytes = rd_bytes_ff + charge_ff[SW-1:0];
            end
         end
      end

      if (cmd.pop) begin
         sum_in    = sum_ff + rd_bytes_ff;
         rp_in     = rp_next;
         count_in  = count_ff - 1'b1;
         mem_re    = 1'b1;
         mem_raddr = rp_next;
      end

      if (cmd.finish) begin
         unused_in     = free_unused;
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_offset_in = '0;
         rsp_freed_in  = FW'(sum_ff);
         rsp_space_in  = FW'(free_unused);
         if (sum_ff > rest_ff) begin
            if (ring_ff == '0) begin
               head_in = '0;
            end else if (excess < ring_ff) begin
               head_in = excess;
            end else begin
               mod_num_in = excess;
               mod_rem_in = '0;
               mod_cnt_in = '0;
            end
         end else if (sum_ff == rest_ff) begin
            head_in = '0;
         end else begin
            head_in = head_ff + sum_ff;
         end
      end

      if (cmd.mod_step) begin
         mod_rem_in = rem_shift[SW-1:0];
         mod_num_in = mod_num_ff << 1;
         mod_cnt_in = mod_cnt_ff + 1'b1;
         if (sts.mod_last) begin
            head_in = rem_shift[SW-1:0];
         end
      end

      // A size write restarts the ring empty.
      if (csr_we) begin
         ring_in   = SW'(csr_wdata);
         unused_in = SW'(csr_wdata);
         head_in   = '0;
         tail_in   = '0;
         rp_in     = '0;
         wp_in     = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff      <= SW'(RING_SIZE_RESET);
         unused_ff    <= SW'(RING_SIZE_RESET);
         head_ff      <= '0;
         tail_ff      <= '0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ring_ff      <= ring_in;
         unused_ff    <= unused_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff   <= req_size_in;
      frame_ff      <= frame_in;
      charge_ff     <= charge_in;
      offset_ff     <= offset_in;
      wrap_ff       <= wrap_in;
      need_new_ff   <= need_new_in;
      status_ff     <= status_in;
      rest_ff       <= rest_in;
      used_ff       <= used_in;
      sum_ff        <= sum_in;
      mod_rem_ff    <= mod_rem_in;
      mod_num_ff    <= mod_num_in;
      mod_cnt_ff    <= mod_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_space_ff  <= rsp_space_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_bytes_mem[mem_waddr] <= mem_wbytes;
         if (mem_wframe) begin
            rec_frame_mem[mem_waddr] <= frame_ff;
         end
      end
      if (mem_re) begin
         rd_bytes_ff <= rec_bytes_mem[mem_raddr];
         rd_frame_ff <= rec_frame_mem[mem_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_freed_bytes = rsp_freed_ff;
   assign rsp_free_space  = rsp_space_ff;

endmodule

### design/frame_fenced_ring_allocator_top.sv
// frame_fenced_ring_allocator_top.sv: top level of the frame fenced ring allocator.
// Depends on frfa_pkg, frfa_ctrl, frfa_dpath and assert_macros.svh.

// The allocator hands out contiguous byte ranges from a ring whose size is set
// through csr_we and csr_wdata; a size write restarts the ring empty and must
// only be issued while busy is low and no result is pending. A transaction is
// accepted at a clock edge where start is high and busy is low. Every
// transaction produces exactly one result, presented for one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take the result in
// that cycle. A new transaction can be accepted in the same cycle that an
// allocate result is shown. An allocate reads the newest record from the
// record memory at acceptance, checks fit and the record rule in its
// evaluate state and updates the ring in its update state. A free
// transaction pops one record per cycle from the record memory and then
// shows its result. When the released bytes carry the head past the end of
// the ring by a whole ring size or more, the head is reduced by a bit-serial
// remainder unit that keeps busy high until its last step, after the result
// has been shown; otherwise the next transaction can start when the result
// is shown. Refused allocations change nothing and return offset zero.
`include "assert_macros.svh"

module frame_fenced_ring_allocator_top #(
   parameter int RECORD_DEPTH = 16,
   parameter int SIZE_WIDTH   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [frfa_pkg::FIELD_WIDTH-1:0] req_request_size,
   input  logic [frfa_pkg::FIELD_WIDTH-1:0] req_frame,
   input  logic                             csr_we,
   input  logic [frfa_pkg::FIELD_WIDTH-1:0] csr_wdata,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [frfa_pkg::FIELD_WIDTH-1:0] rsp_offset,
   output logic [frfa_pkg::FIELD_WIDTH-1:0] rsp_freed_bytes,
   output logic [frfa_pkg::FIELD_WIDTH-1:0] rsp_free_space
);
   import frfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller sequences each transaction; it sees only the handshake,
   // the operation code and a few status flags from the datapath.
   frfa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .cmd           (cmd),
      .sts           (sts)
   );

   // The datapath holds the ring pointers, the record memory and the result
   // registers, and performs the arithmetic that each command asks for.
   frfa_dpath #(
      .RECORD_DEPTH (RECORD_DEPTH),
      .SIZE_WIDTH   (SIZE_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_request_size (req_request_size),
      .req_frame        (req_frame),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_offset       (rsp_offset),
      .rsp_freed_bytes  (rsp_freed_bytes),
      .rsp_free_space   (rsp_free_space)
   );

   // An accepted transaction always occupies the block in the following cycle.
   `ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy)
   // An allocate transaction shows its result once its evaluate and update states have passed.
   `ASSERT_LATER(a_alloc_latency, clock, reset, start && !busy && req_operation == OP_ALLOC, 3, rsp_valid)
   // A refused allocation reports neither an offset nor released bytes.
   `ASSERT_IMPLY(a_refusal_clean, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_offset == '0 && rsp_freed_bytes == '0)
   // A result is only shown right after the block has been working.
   `ASSERT_IMPLY(a_result_follows_work, clock, reset, rsp_valid, $past(busy))

endmodule
